// ===== sv/fifo_or_shortest_job_queue_top_defines.svh =====
// Assertion macros for the job queue checker.
// Depends on nothing; the including scope must provide clk and rst.
`ifndef FIFO_OR_SHORTEST_JOB_QUEUE_TOP_DEFINES_SVH
`define FIFO_OR_SHORTEST_JOB_QUEUE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FOSJQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("job queue check failed");

// Consequent must hold in the cycle after the antecedent.
`define FOSJQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("job queue check failed");

`endif

// ===== sv/fosjq_pkg.sv =====
// Shared types and constants for the FIFO or shortest-job-next queue.
// Used by the cell, the top level and the checker; depends on nothing.
package fosjq_pkg;

  localparam int Depth  = 64;
  localparam int CountW = $clog2(Depth + 1);
  localparam int CapW   = 7;
  localparam int CmpW   = (CountW > CapW) ? CountW : CapW;
  localparam int WordW  = 32;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t id;
    word_t len;
  } entry_t;

  typedef struct packed {
    logic live;
    logic load_new;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    StatusDone  = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_t;

  localparam logic ModeEnqueue = 1'b0;
  localparam logic ModeDequeue = 1'b1;

  localparam logic CfgPolicy   = 1'b0;
  localparam logic CfgCapacity = 1'b1;

  localparam logic PolicyFifo = 1'b0;
  localparam logic PolicySjn  = 1'b1;

endpackage

// ===== sv/fifo_or_shortest_job_queue_top.sv =====
// Job queue top level: a row of slots kept in queue order, head in slot 0.
// The start transfer sets busy, and busy is registered into the result strobe.
// Each operation passes a capture step and an execute step; a new one is taken only while busy is low.
// Reset clears the entry count (not the occupancy output), policy to FIFO and capacity to the full depth.
// The receiver cannot stall; each result is shown for one cycle.
module fifo_or_shortest_job_queue_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      mode,
  input  logic [31:0]               request_id,
  input  logic [31:0]               job_length,
  output logic                      done,
  output logic [1:0]                status,
  output logic [31:0]               head_request_id,
  output logic [31:0]               head_job_length,
  output logic [6:0]                occupancy,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [6:0]                cfg_data
);

  logic                            policy;
  logic [fosjq_pkg::CapW-1:0]      capacity;
  logic [fosjq_pkg::CountW-1:0]    count;
  logic [fosjq_pkg::CountW-1:0]    count_next;
  logic                            pending;
  logic                            op_mode;
  fosjq_pkg::entry_t               op_item;

  fosjq_pkg::entry_t               entries [fosjq_pkg::Depth];
  logic [fosjq_pkg::Depth-1:0]     gt;
  logic                            any_gt;
  logic                            sjn;
  logic                            full;
  logic                            enq_ok;
  logic                            deq_ok;
  logic [fosjq_pkg::CmpW-1:0]      cap_cmp;
  logic [fosjq_pkg::CmpW-1:0]      cap_eff;
  logic [fosjq_pkg::CmpW-1:0]      depth_cmp;

  assign busy      = pending;
  assign sjn       = (policy == fosjq_pkg::PolicySjn);
  assign any_gt    = |gt;
  assign cap_cmp   = fosjq_pkg::CmpW'(capacity);
  assign depth_cmp = fosjq_pkg::CmpW'(fosjq_pkg::Depth);

  always_comb begin
    if (cap_cmp == '0) begin
      cap_eff = fosjq_pkg::CmpW'(1);
    end else if (cap_cmp > depth_cmp) begin
      cap_eff = depth_cmp;
    end else begin
      cap_eff = cap_cmp;
    end
    full   = fosjq_pkg::CmpW'(count) >= cap_eff;
    enq_ok = pending && (op_mode == fosjq_pkg::ModeEnqueue) && !full;
    deq_ok = pending && (op_mode == fosjq_pkg::ModeDequeue) && (count != '0);
    if (enq_ok) begin
      count_next = count + fosjq_pkg::CountW'(1);
    end else if (deq_ok) begin
      count_next = count - fosjq_pkg::CountW'(1);
    end else begin
      count_next = count;
    end
  end

  for (genvar i = 0; i < fosjq_pkg::Depth; i++) begin : g_cell
    localparam logic [fosjq_pkg::Depth-1:0] Below =
      (fosjq_pkg::Depth'(1) << i) - fosjq_pkg::Depth'(1);
    fosjq_pkg::cell_ctl_t ctl;
    fosjq_pkg::entry_t    left;
    fosjq_pkg::entry_t    right;
    logic                 prior_gt;
    logic                 tail;

    assign prior_gt = |(gt & Below);
    assign tail     = (count == fosjq_pkg::CountW'(i));

    always_comb begin
      ctl.live       = fosjq_pkg::CountW'(i) < count;
      ctl.load_new   = enq_ok && (sjn ? ((gt[i] && !prior_gt) || (!any_gt && tail)) : tail);
      ctl.take_left  = enq_ok && sjn && prior_gt;
      ctl.take_right = deq_ok;
    end

    if (i == 0) begin : g_first
      assign left = op_item;
    end else begin : g_inner_left
      assign left = entries[i-1];
    end

    if (i == fosjq_pkg::Depth - 1) begin : g_last
      assign right = entries[i];
    end else begin : g_inner_right
      assign right = entries[i+1];
    end

    fosjq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .new_item (op_item),
      .left     (left),
      .right    (right),
      .entry    (entries[i]),
      .gt       (gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy   <= fosjq_pkg::PolicyFifo;
      capacity <= fosjq_pkg::CapW'(64);
      count    <= '0;
      pending  <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fosjq_pkg::CfgPolicy:   policy   <= cfg_data[0];
          fosjq_pkg::CfgCapacity: capacity <= cfg_data;
          default:                ;
        endcase
      end
      count <= count_next;
      done  <= pending;
      if (pending) begin
        pending <= 1'b0;
      end else if (start) begin
        pending <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !pending) begin
      op_mode     <= mode;
      op_item.id  <= request_id;
      op_item.len <= job_length;
    end
    if (pending) begin
      occupancy <= fosjq_pkg::CapW'(count_next);
      if (op_mode == fosjq_pkg::ModeDequeue) begin
        status <= (count == '0) ? fosjq_pkg::StatusEmpty : fosjq_pkg::StatusDone;
      end else begin
        status <= full ? fosjq_pkg::StatusFull : fosjq_pkg::StatusDone;
      end
      if (deq_ok) begin
        head_request_id <= entries[0].id;
        head_job_length <= entries[0].len;
      end else begin
        head_request_id <= '0;
        head_job_length <= '0;
      end
    end
  end

endmodule

// ===== sv/fosjq_cell.sv =====
// One queue slot: holds an entry, compares its length with the incoming one,
// and loads new, left-neighbor or right-neighbor data. Depends on fosjq_pkg.
module fosjq_cell (
  input  logic                clk,
  input  fosjq_pkg::cell_ctl_t ctl,
  input  fosjq_pkg::entry_t   new_item,
  input  fosjq_pkg::entry_t   left,
  input  fosjq_pkg::entry_t   right,
  output fosjq_pkg::entry_t   entry,
  output logic                gt
);

  assign gt = ctl.live && (new_item.len < entry.len);

  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      entry <= new_item;
    end else if (ctl.take_left) begin
      entry <= left;
    end else if (ctl.take_right) begin
      entry <= right;
    end
  end

endmodule

// ===== sv/fosjq_checker.sv =====
// Port-level checker for the job queue, bound to the top level.
// Depends on fosjq_pkg and the assertion macros header.
`include "fifo_or_shortest_job_queue_top_defines.svh"

module fosjq_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [31:0] head_request_id,
  input logic [31:0] head_job_length,
  input logic [6:0]  occupancy
);

  `FOSJQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `FOSJQ_ASSERT_NEXT(a_busy_done, busy, done && !busy)
  `FOSJQ_ASSERT_NOW(a_status_code, done, status == fosjq_pkg::StatusDone || status == fosjq_pkg::StatusFull || status == fosjq_pkg::StatusEmpty)
  `FOSJQ_ASSERT_NOW(a_empty_result, done && status == fosjq_pkg::StatusEmpty, occupancy == 7'd0 && head_request_id == 32'd0 && head_job_length == 32'd0)
  `FOSJQ_ASSERT_NOW(a_full_result, done && status == fosjq_pkg::StatusFull, occupancy != 7'd0)

endmodule

bind fifo_or_shortest_job_queue_top fosjq_checker u_fosjq_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .status          (status),
  .head_request_id (head_request_id),
  .head_job_length (head_job_length),
  .occupancy       (occupancy)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the FIFO or shortest-job-next request queue.
// It drives directed and random operations and register writes, and it predicts
// each result. Depends on fosjq_pkg and fifo_or_shortest_job_queue_top.
module tb_top;
  import fosjq_pkg::*;

  typedef enum logic [1:0] {
    OpJob,
    OpWrite,
    OpDrain
  } op_kind_t;

  typedef struct {
    op_kind_t    kind;
    logic        mode;
    word_t       id;
    word_t       len;
    logic        idx;
    logic [6:0]  data;
    int unsigned idle;
  } queue_op_t;

  typedef struct {
    status_t    status;
    word_t      id;
    word_t      len;
    logic [6:0] occ;
  } queue_result_t;

  localparam int StallLimit = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = ModeEnqueue;
  logic [31:0] request_id = '0;
  logic [31:0] job_length = '0;
  logic        done;
  logic [1:0]  status;
  logic [31:0] head_request_id;
  logic [31:0] head_job_length;
  logic [6:0]  occupancy;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CfgPolicy;
  logic [6:0]  cfg_data = '0;

  queue_op_t     job_ops[$];
  queue_result_t due_results[$];
  entry_t        model_slots[$];
  logic          model_policy = PolicyFifo;
  logic [6:0]    model_cap = 7'd64;
  int            n_accepted = 0;
  int            n_results = 0;
  int            errors = 0;
  int            stall_cycles = 0;

  fifo_or_shortest_job_queue_top DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .request_id(request_id),
    .job_length(job_length),
    .done(done),
    .status(status),
    .head_request_id(head_request_id),
    .head_job_length(head_job_length),
    .occupancy(occupancy),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic queue_result_t predict_queue_op(logic op_mode, word_t id, word_t len);
    queue_result_t r;
    entry_t        e;
    int            cap;
    int            pos;
    r.status = StatusDone;
    r.id = '0;
    r.len = '0;
    cap = (model_cap == 0) ? 1 : ((model_cap > Depth) ? Depth : int'(model_cap));
    if (op_mode == ModeEnqueue) begin
      if (model_slots.size() >= cap) begin
        r.status = StatusFull;
      end else begin
        e.id = id;
        e.len = len;
        pos = model_slots.size();
        if (model_policy == PolicySjn) begin
          for (int k = 0; k < model_slots.size(); k++) begin
            if (len < model_slots[k].len) begin
              pos = k;
              break;
            end
          end
        end
        model_slots.insert(pos, e);
      end
    end else if (model_slots.size() == 0) begin
      r.status = StatusEmpty;
    end else begin
      e = model_slots.pop_front();
      r.id = e.id;
      r.len = e.len;
    end
    r.occ = 7'(model_slots.size());
    return r;
  endfunction

  // The driver predicts on each start transfer and writes registers only when idle.
  always @(posedge clk) begin : drive_ops
    logic      next_start;
    logic      next_we;
    queue_op_t op;
    next_start = start;
    next_we = 1'b0;
    if (rst) begin
      next_start = 1'b0;
    end else begin
      if (start && !busy) begin
        due_results.push_back(predict_queue_op(mode, request_id, job_length));
        n_accepted++;
        next_start = 1'b0;
      end
      if (!next_start && job_ops.size() > 0) begin
        if (job_ops[0].kind == OpJob) begin
          if (job_ops[0].idle > 0) begin
            job_ops[0].idle--;
          end else begin
            op = job_ops.pop_front();
            next_start = 1'b1;
            mode <= op.mode;
            request_id <= op.id;
            job_length <= op.len;
          end
        end else if (n_accepted == n_results && !busy) begin
          op = job_ops.pop_front();
          if (op.kind == OpWrite) begin
            next_we = 1'b1;
            cfg_index <= op.idx;
            cfg_data <= op.data;
            if (op.idx == CfgPolicy) begin
              model_policy = op.data[0];
            end else begin
              model_cap = op.data;
            end
          end
        end
      end
    end
    start <= next_start;
    cfg_we <= next_we;
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (!rst && done) begin
      n_results <= n_results + 1;
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing expected, status expected none actual %0d",
                 $time, status);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("head_request_id", want.id, head_request_id);
        check_field("head_job_length", want.len, head_job_length);
        check_field("occupancy", 32'(want.occ), 32'(occupancy));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic add_job(logic op_mode, word_t id, word_t len, int unsigned idle);
    queue_op_t op;
    op.kind = OpJob;
    op.mode = op_mode;
    op.id = id;
    op.len = len;
    op.idx = CfgPolicy;
    op.data = '0;
    op.idle = idle;
    job_ops.push_back(op);
  endtask

  task automatic add_write(logic idx, logic [6:0] data);
    queue_op_t op;
    op.kind = OpWrite;
    op.mode = ModeEnqueue;
    op.id = '0;
    op.len = '0;
    op.idx = idx;
    op.data = data;
    op.idle = 0;
    job_ops.push_back(op);
  endtask

  task automatic add_drain();
    queue_op_t op;
    op.kind = OpDrain;
    op.mode = ModeEnqueue;
    op.id = '0;
    op.len = '0;
    op.idx = CfgPolicy;
    op.data = '0;
    op.idle = 0;
    job_ops.push_back(op);
  endtask

  function automatic word_t pick_len();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return word_t'($urandom_range(0, 15));
      default: return word_t'($urandom);
    endcase
  endfunction

  initial begin
    int          n_phases;
    int          n_items;
    int          enq_pct;
    bit          quiet;
    logic [6:0]  cap;
    logic        op_mode;
    int unsigned idle;
    n_phases = 14;

    // Directed: empty dequeue, field extremes, a policy change with entries
    // stored, a capacity of zero that is lowered below occupancy, and an
    // oversized capacity.
    add_job(ModeDequeue, '1, '1, 0);
    add_job(ModeEnqueue, '0, '0, 0);
    add_job(ModeEnqueue, '1, '1, 0);
    add_job(ModeEnqueue, $urandom, 32'd5, 2);
    add_write(CfgPolicy, {6'd0, PolicySjn});
    add_job(ModeEnqueue, $urandom, 32'd3, 0);
    add_write(CfgCapacity, 7'd0);
    add_job(ModeEnqueue, $urandom, 32'd1, 0);
    for (int i = 0; i < 5; i++) begin
      add_job(ModeDequeue, $urandom, $urandom, 0);
    end
    add_job(ModeEnqueue, $urandom, 32'd7, 0);
    add_job(ModeEnqueue, $urandom, 32'd2, 0);
    add_write(CfgCapacity, 7'd127);

    for (int p = 0; p < n_phases; p++) begin
      add_drain();
      add_write(CfgPolicy, {6'd0, (p < 4) ? logic'(p % 2) : logic'($urandom_range(0, 1))});
      case (p)
        0: cap = 7'd64;
        1: cap = 7'd1;
        2: cap = 7'd0;
        3: cap = 7'd127;
        default: cap = ($urandom_range(0, 2) == 0) ? 7'($urandom_range(1, 64))
                                                   : 7'($urandom_range(1, 6));
      endcase
      add_write(CfgCapacity, cap);
      n_items = (p == 0) ? 80 : 45;
      case ($urandom_range(0, 3))
        0: enq_pct = 30;
        1: enq_pct = 50;
        2: enq_pct = 70;
        default: enq_pct = 95;
      endcase
      if (p == 0 || p == 3) begin
        enq_pct = 98;
      end
      quiet = (p >= n_phases - 2) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n_items; i++) begin
        op_mode = ($urandom_range(1, 100) <= enq_pct) ? ModeEnqueue : ModeDequeue;
        idle = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        if (!quiet && $urandom_range(0, 39) == 0) begin
          add_drain();
        end
        add_job(op_mode, $urandom, pick_len(), idle);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (job_ops.size() != 0 || start || n_accepted != n_results) begin
      @(negedge clk);
    end
    repeat (8) @(posedge clk);
    if (due_results.size() != 0) begin
      $display("%0t: %0d results expected but never seen", $time, due_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/fosjq_pkg.sv
sv/fosjq_cell.sv
sv/fifo_or_shortest_job_queue_top.sv
sv/fosjq_checker.sv
verif/tb_top.sv
